// ----- src/gpp_pkg.sv -----
`default_nettype none

package gpp_pkg;

    // Field widths fixed by the interface
    localparam int FIELD_COORD_WIDTH   = 16;
    localparam int COLOR_WIDTH         = 8;
    localparam int OFFSET_WIDTH        = 29;
    localparam int DIM_WIDTH           = 9;
    localparam int DEPTH_WIDTH         = 2;

    // Default for the coordinate width used by the datapath
    localparam int COORD_WIDTH_DEFAULT = 16;

    // Quotient bits resolved by each divider stage
    localparam int DIV_STEP_BITS       = 4;

    // Register stages after the divider: geometry, code, product, output
    localparam int INDEX_STAGES        = 4;

    // APB port
    localparam int APB_ADDR_WIDTH      = 5;
    localparam int APB_DATA_WIDTH      = 32;

    // Register reset values
    localparam logic [DIM_WIDTH-1:0]   GLYPH_WIDTH_RESET   = 9'd8;
    localparam logic [DIM_WIDTH-1:0]   GLYPH_HEIGHT_RESET  = 9'd8;
    localparam logic [DEPTH_WIDTH-1:0] DEPTH_LOG2_RESET    = 2'd0;
    localparam logic [DIM_WIDTH-1:0]   SHEET_COLUMNS_RESET = 9'd16;
    localparam logic [DIM_WIDTH-1:0]   SHEET_ROWS_RESET    = 9'd6;

    typedef enum logic [2:0] {
        REG_GLYPH_WIDTH   = 3'd0,
        REG_GLYPH_HEIGHT  = 3'd1,
        REG_DEPTH_LOG2    = 3'd2,
        REG_SHEET_COLUMNS = 3'd3,
        REG_SHEET_ROWS    = 3'd4
    } t_reg_index;

    // Input word: one pixel of the sheet image
    typedef struct packed {
        logic [FIELD_COORD_WIDTH-1:0] pixel_x;
        logic [FIELD_COORD_WIDTH-1:0] pixel_y;
        logic [COLOR_WIDTH-1:0]       red;
        logic [COLOR_WIDTH-1:0]       green;
        logic [COLOR_WIDTH-1:0]       blue;
    } t_pixel_word;

    // Output word: byte update for the packed charset
    typedef struct packed {
        logic [OFFSET_WIDTH-1:0] byte_offset;
        logic [7:0]              or_bits;
        logic                    in_range;
    } t_result_word;

    // Effective (clamped) configuration seen by the datapath
    typedef struct packed {
        logic [DIM_WIDTH-1:0]   glyph_width;
        logic [DIM_WIDTH-1:0]   glyph_height;
        logic [DEPTH_WIDTH-1:0] depth_log2;
        logic [DIM_WIDTH-1:0]   sheet_columns;
        logic [DIM_WIDTH-1:0]   sheet_rows;
    } t_cfg;

endpackage

`default_nettype wire

// ----- src/gpp_cfg_regs.sv -----
`default_nettype none

module gpp_cfg_regs (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [gpp_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  wire logic [gpp_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic      [gpp_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                      pready,
    output gpp_pkg::t_cfg                             o_cfg
);

    localparam int DW = gpp_pkg::DIM_WIDTH;

    logic [DW-1:0]                       r_glyph_width;
    logic [DW-1:0]                       r_glyph_height;
    logic [gpp_pkg::DEPTH_WIDTH-1:0]     r_depth_log2;
    logic [DW-1:0]                       r_sheet_columns;
    logic [DW-1:0]                       r_sheet_rows;
    gpp_pkg::t_reg_index                 reg_sel;
    logic                                wr_en;

    // Zero acts as one, anything above 256 as 256
    function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
        logic [DW-1:0] res;
        if (v == '0) begin
            res = DW'(1);
        end else if (v > DW'(256)) begin
            res = DW'(256);
        end else begin
            res = v;
        end
        return res;
    endfunction

    assign reg_sel = gpp_pkg::t_reg_index'(paddr[gpp_pkg::APB_ADDR_WIDTH-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_width   <= gpp_pkg::GLYPH_WIDTH_RESET;
            r_glyph_height  <= gpp_pkg::GLYPH_HEIGHT_RESET;
            r_depth_log2    <= gpp_pkg::DEPTH_LOG2_RESET;
            r_sheet_columns <= gpp_pkg::SHEET_COLUMNS_RESET;
            r_sheet_rows    <= gpp_pkg::SHEET_ROWS_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                gpp_pkg::REG_GLYPH_WIDTH:   r_glyph_width   <= pwdata[DW-1:0];
                gpp_pkg::REG_GLYPH_HEIGHT:  r_glyph_height  <= pwdata[DW-1:0];
                gpp_pkg::REG_DEPTH_LOG2:    r_depth_log2    <= pwdata[gpp_pkg::DEPTH_WIDTH-1:0];
                gpp_pkg::REG_SHEET_COLUMNS: r_sheet_columns <= pwdata[DW-1:0];
                gpp_pkg::REG_SHEET_ROWS:    r_sheet_rows    <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    // Read back the raw values
    always_comb begin
        case (reg_sel)
            gpp_pkg::REG_GLYPH_WIDTH:   prdata = gpp_pkg::APB_DATA_WIDTH'(r_glyph_width);
            gpp_pkg::REG_GLYPH_HEIGHT:  prdata = gpp_pkg::APB_DATA_WIDTH'(r_glyph_height);
            gpp_pkg::REG_DEPTH_LOG2:    prdata = gpp_pkg::APB_DATA_WIDTH'(r_depth_log2);
            gpp_pkg::REG_SHEET_COLUMNS: prdata = gpp_pkg::APB_DATA_WIDTH'(r_sheet_columns);
            gpp_pkg::REG_SHEET_ROWS:    prdata = gpp_pkg::APB_DATA_WIDTH'(r_sheet_rows);
            default:                    prdata = '0;
        endcase
    end

    // Effective configuration
    always_comb begin
        o_cfg.glyph_width   = clamp_dim(r_glyph_width);
        o_cfg.glyph_height  = clamp_dim(r_glyph_height);
        o_cfg.depth_log2    = r_depth_log2;
        o_cfg.sheet_columns = clamp_dim(r_sheet_columns);
        o_cfg.sheet_rows    = clamp_dim(r_sheet_rows);
    end

endmodule

`default_nettype wire

// ----- src/gpp_div_pipe.sv -----
`default_nettype none

// Pipelined restoring divider: pixel_x / glyph_width and pixel_y / glyph_height,
// DIV_STEP_BITS quotient bits per stage. Luminance rides along.
module gpp_div_pipe #(
    parameter int COORD_WIDTH = gpp_pkg::COORD_WIDTH_DEFAULT
) (
    input  wire logic                                    i_clk,
    input  wire logic [(COORD_WIDTH + gpp_pkg::DIV_STEP_BITS - 1)
                       / gpp_pkg::DIV_STEP_BITS - 1:0]   i_en,
    input  wire gpp_pkg::t_cfg                           i_cfg,
    input  wire gpp_pkg::t_pixel_word                    i_word,
    output logic      [COORD_WIDTH-1:0]                  o_gcol,
    output logic      [COORD_WIDTH-1:0]                  o_grow,
    output logic      [7:0]                              o_cx,
    output logic      [7:0]                              o_cy,
    output logic      [gpp_pkg::COLOR_WIDTH-1:0]         o_lum
);

    localparam int DIV_STAGES = (COORD_WIDTH + gpp_pkg::DIV_STEP_BITS - 1)
                                / gpp_pkg::DIV_STEP_BITS;
    localparam int QW         = DIV_STAGES * gpp_pkg::DIV_STEP_BITS;
    localparam int AW         = QW + 8;

    // Accumulator: {remainder[7:0], dividend bits shifting into quotient}
    logic [AW-1:0]                     r_acc_x [DIV_STAGES];
    logic [AW-1:0]                     r_acc_y [DIV_STAGES];
    logic [gpp_pkg::COLOR_WIDTH-1:0]   r_lum   [DIV_STAGES];

    logic [AW-1:0]                     init_x;
    logic [AW-1:0]                     init_y;
    logic [9:0]                        color_sum;
    logic [19:0]                       lum_prod;
    logic [gpp_pkg::COLOR_WIDTH-1:0]   lum_in;

    // Several restoring steps; remainder stays below d <= 256
    function automatic logic [AW-1:0] div_steps(input logic [AW-1:0] acc,
                                                input logic [8:0] d);
        logic [8:0]    t;
        logic [7:0]    rem;
        logic [QW-1:0] q;
        rem = acc[AW-1:QW];
        q   = acc[QW-1:0];
        for (int i = 0; i < gpp_pkg::DIV_STEP_BITS; i++) begin
            t = {rem, q[QW-1]};
            q = {q[QW-2:0], 1'b0};
            if (t >= d) begin
                t    = t - d;
                q[0] = 1'b1;
            end
            rem = t[7:0];
        end
        return {rem, q};
    endfunction

    // Stage 0 operands; luminance = sum/3 as (sum*683)>>11, exact below 768
    always_comb begin
        init_x    = AW'(i_word.pixel_x[COORD_WIDTH-1:0]);
        init_y    = AW'(i_word.pixel_y[COORD_WIDTH-1:0]);
        color_sum = 10'(i_word.red) + 10'(i_word.green) + 10'(i_word.blue);
        lum_prod  = 20'(color_sum) * 20'd683;
        lum_in    = lum_prod[18:11];
    end

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [AW-1:0]                   acc_x_in;
        logic [AW-1:0]                   acc_y_in;
        logic [gpp_pkg::COLOR_WIDTH-1:0] lum_prev;

        if (s == 0) begin : g_first
            assign acc_x_in = init_x;
            assign acc_y_in = init_y;
            assign lum_prev = lum_in;
        end else begin : g_next
            assign acc_x_in = r_acc_x[s-1];
            assign acc_y_in = r_acc_y[s-1];
            assign lum_prev = r_lum[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_acc_x[s] <= div_steps(acc_x_in, i_cfg.glyph_width);
                r_acc_y[s] <= div_steps(acc_y_in, i_cfg.glyph_height);
                r_lum[s]   <= lum_prev;
            end
        end
    end

    assign o_gcol = r_acc_x[DIV_STAGES-1][COORD_WIDTH-1:0];
    assign o_grow = r_acc_y[DIV_STAGES-1][COORD_WIDTH-1:0];
    assign o_cx   = r_acc_x[DIV_STAGES-1][AW-1:QW];
    assign o_cy   = r_acc_y[DIV_STAGES-1][AW-1:QW];
    assign o_lum  = r_lum[DIV_STAGES-1];

endmodule

`default_nettype wire

// ----- src/gpp_index_calc.sv -----
`default_nettype none

// Glyph code, byte offset and shifted opacity bits, four register stages
module gpp_index_calc #(
    parameter int COORD_WIDTH = gpp_pkg::COORD_WIDTH_DEFAULT
) (
    input  wire logic                                    i_clk,
    input  wire logic [gpp_pkg::INDEX_STAGES-1:0]        i_en,
    input  wire gpp_pkg::t_cfg                           i_cfg,
    input  wire logic [COORD_WIDTH-1:0]                  i_gcol,
    input  wire logic [COORD_WIDTH-1:0]                  i_grow,
    input  wire logic [7:0]                              i_cx,
    input  wire logic [7:0]                              i_cy,
    input  wire logic [gpp_pkg::COLOR_WIDTH-1:0]         i_lum,
    output gpp_pkg::t_result_word                        o_word
);

    localparam int CMPW  = COORD_WIDTH + 1;
    localparam int CGW   = COORD_WIDTH + 9;
    localparam int CODEW = COORD_WIDTH + 10;
    localparam int OFFW  = gpp_pkg::OFFSET_WIDTH;

    // Combinational geometry for stage 1
    logic [1:0]  lg;
    logic [3:0]  bpp;
    logic [3:0]  ppb;
    logic [1:0]  psr;
    logic [8:0]  row_bytes;
    logic [7:0]  opa;
    logic [2:0]  pix_in_byte;
    logic [2:0]  sh;
    logic [7:0]  or_bits;
    logic        in_sheet;

    // Stage 1
    logic             r1_inside;
    logic [COORD_WIDTH-1:0] r1_gcol;
    logic [CGW-1:0]   r1_colsgrow;
    logic [17:0]      r1_gbytes;
    logic [16:0]      r1_cyoff;
    logic [7:0]       r1_bir;
    logic [7:0]       r1_or;
    // Stage 2
    logic             r2_inside;
    logic [CODEW-1:0] r2_code;
    logic [17:0]      r2_gbytes;
    logic [16:0]      r2_part;
    logic [7:0]       r2_or;
    // Stage 3
    logic             r3_inside;
    logic [OFFW-1:0]  r3_prod;
    logic [16:0]      r3_part;
    logic [7:0]       r3_or;
    // Output stage
    gpp_pkg::t_result_word r4_word;

    always_comb begin
        lg          = i_cfg.depth_log2;
        bpp         = 4'(4'd1 << lg);
        ppb         = 4'(4'd8 >> lg);
        psr         = 2'(2'd3 - lg);
        row_bytes   = 9'((10'(i_cfg.glyph_width) + 10'(ppb) - 10'd1) >> psr);
        opa         = 8'((8'd255 - i_lum) >> (4'd8 - bpp));
        pix_in_byte = 3'(i_cx & 8'(ppb - 4'd1));
        sh          = 3'(4'(4'd8 - bpp) - 4'(4'(pix_in_byte) << lg));
        or_bits     = 8'(opa << sh);
        in_sheet    = (CMPW'(i_gcol) < CMPW'(i_cfg.sheet_columns))
                   && (CMPW'(i_grow) < CMPW'(i_cfg.sheet_rows));
    end

    // Stage 1: bounds and the narrow products
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_inside   <= in_sheet;
            r1_gcol     <= i_gcol;
            r1_colsgrow <= CGW'(i_cfg.sheet_columns) * CGW'(i_grow);
            r1_gbytes   <= 18'(i_cfg.glyph_height) * 18'(row_bytes);
            r1_cyoff    <= 17'(i_cy) * 17'(row_bytes);
            r1_bir      <= 8'(i_cx >> psr);
            r1_or       <= or_bits;
        end
    end

    // Stage 2: glyph code and in-glyph byte
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_inside <= r1_inside;
            r2_code   <= CODEW'(r1_gcol) + CODEW'(r1_colsgrow);
            r2_gbytes <= r1_gbytes;
            r2_part   <= r1_cyoff + 17'(r1_bir);
            r2_or     <= r1_or;
        end
    end

    // Stage 3: glyph base, kept modulo 2^29
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_inside <= r2_inside;
            r3_prod   <= OFFW'(r2_code) * OFFW'(r2_gbytes);
            r3_part   <= r2_part;
            r3_or     <= r2_or;
        end
    end

    // Output register: final add, zero fields when out of range
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            if (r3_inside) begin
                r4_word.byte_offset <= r3_prod + OFFW'(r3_part);
                r4_word.or_bits     <= r3_or;
                r4_word.in_range    <= 1'b1;
            end else begin
                r4_word.byte_offset <= '0;
                r4_word.or_bits     <= '0;
                r4_word.in_range    <= 1'b0;
            end
        end
    end

    assign o_word = r4_word;

endmodule

`default_nettype wire

// ----- src/glyph_pixel_packer_unit.sv -----
// Channel | Direction | Handshake                  | Word
// --------+-----------+----------------------------+-----------------------
// in      | input     | i_in_valid / o_in_stall    | i_in_word  (t_pixel_word)
// out     | output    | o_out_valid / i_out_stall  | o_out_word (t_result_word)
// cfg     | input     | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One word per cycle sustained while the output is not stalled; the divider
// resolves 4 quotient bits per stage; the index path forms a 29-bit product.
// Reset is synchronous: clears stage valid bits, reloads config registers.
// A stall backs up stage by stage; empty stages still fill, so input stalls
// only when every stage holds a word and the output is stalled.
`default_nettype none

module glyph_pixel_packer_unit #(
    parameter int COORD_WIDTH = gpp_pkg::COORD_WIDTH_DEFAULT
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire gpp_pkg::t_pixel_word                 i_in_word,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output gpp_pkg::t_result_word                     o_out_word,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [gpp_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  wire logic [gpp_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic      [gpp_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                      pready
);

    localparam int DIV_STAGES = (COORD_WIDTH + gpp_pkg::DIV_STEP_BITS - 1)
                                / gpp_pkg::DIV_STEP_BITS;
    localparam int NS         = DIV_STAGES + gpp_pkg::INDEX_STAGES;

    gpp_pkg::t_cfg                    cfg;
    logic [NS-1:0]                    r_valid;
    logic [NS-1:0]                    n_valid;
    logic [NS:0]                      ready;
    logic [COORD_WIDTH-1:0]           gcol;
    logic [COORD_WIDTH-1:0]           grow;
    logic [7:0]                       cx;
    logic [7:0]                       cy;
    logic [gpp_pkg::COLOR_WIDTH-1:0]  lum;

    gpp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // A stage loads when it is empty or its successor moves on
    always_comb begin
        ready[NS] = !i_out_stall;
        for (int k = NS - 1; k >= 0; k--) begin
            ready[k] = !r_valid[k] || ready[k+1];
        end
    end

    always_comb begin
        n_valid[0] = ready[0] ? i_in_valid : r_valid[0];
        for (int k = 1; k < NS; k++) begin
            if (ready[k]) begin
                n_valid[k] = r_valid[k-1];
            end else begin
                n_valid[k] = r_valid[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_stall  = !ready[0];
    assign o_out_valid = r_valid[NS-1];

    gpp_div_pipe #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_div (
        .i_clk  (i_clk),
        .i_en   (ready[DIV_STAGES-1:0]),
        .i_cfg  (cfg),
        .i_word (i_in_word),
        .o_gcol (gcol),
        .o_grow (grow),
        .o_cx   (cx),
        .o_cy   (cy),
        .o_lum  (lum)
    );

    gpp_index_calc #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_index (
        .i_clk  (i_clk),
        .i_en   (ready[NS-1:DIV_STAGES]),
        .i_cfg  (cfg),
        .i_gcol (gcol),
        .i_grow (grow),
        .i_cx   (cx),
        .i_cy   (cy),
        .i_lum  (lum),
        .o_word (o_out_word)
    );

`ifndef SYNTH
    // Words in flight change only by what enters and leaves
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
        ($countones(r_valid) == $countones($past(r_valid))
            + int'($past(i_in_valid && !o_in_stall))
            - int'($past(o_out_valid && !i_out_stall))))
        else $error("pipeline occupancy mismatch");

    // Input stalls only when the whole pipeline is full and blocked
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&r_valid) && i_out_stall)
        else $error("input stalled with room in the pipeline");

    // Out-of-range words carry no update
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.in_range) |->
        (o_out_word.byte_offset == '0) && (o_out_word.or_bits == '0))
        else $error("out-of-range word with nonzero fields");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gpp_pkg::*;

    localparam int          PIPE_LATENCY = 8;
    localparam int          DRAIN_CYCLES = 2 * PIPE_LATENCY + 4;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          MAX_REPORTS  = 40;
    localparam logic [2:0]  REG_SPARE    = 3'd5;   // no register behind this index

    // Clock, reset, block inputs (all known from time zero)
    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    t_pixel_word               i_in_word   = '0;
    logic                      i_out_stall = 1'b0;
    logic                      psel        = 1'b0;
    logic                      penable     = 1'b0;
    logic                      pwrite      = 1'b0;
    logic [APB_ADDR_WIDTH-1:0] paddr       = '0;
    logic [APB_DATA_WIDTH-1:0] pwdata      = '0;

    logic                      o_in_stall;
    logic                      o_out_valid;
    t_result_word              o_out_word;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic                      pready;

    // Register copy, raw as written (masked to field width)
    logic [DIM_WIDTH-1:0]   cfg_width   = GLYPH_WIDTH_RESET;
    logic [DIM_WIDTH-1:0]   cfg_height  = GLYPH_HEIGHT_RESET;
    logic [DEPTH_WIDTH-1:0] cfg_depth   = DEPTH_LOG2_RESET;
    logic [DIM_WIDTH-1:0]   cfg_columns = SHEET_COLUMNS_RESET;
    logic [DIM_WIDTH-1:0]   cfg_rows    = SHEET_ROWS_RESET;

    t_pixel_word  pixel_backlog[$];
    t_result_word pending_updates[$];
    int unsigned  pixels_queued = 0;
    int unsigned  pixels_sent   = 0;
    int unsigned  cycle_count   = 0;
    int unsigned  fail_count    = 0;
    bit           word_taken    = 1'b0;
    bit           calm          = 1'b0;   // no idling on either side
    int unsigned  gap_left      = 0;
    int unsigned  stall_left    = 0;

    glyph_pixel_packer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Zero acts as 1, anything above 256 acts as 256
    function automatic int unsigned eff_dim(logic [DIM_WIDTH-1:0] v);
        if (v == 0) return 1;
        if (v > 256) return 256;
        return v;
    endfunction

    // Byte offset and OR mask for one pixel under the current settings
    function automatic t_result_word byte_update_for(t_pixel_word p);
        int unsigned       w, h, cols, rows, lg, bpp, ppb, psr;
        int unsigned       lum, opa, gcol, grow, cx, cy, sh;
        longint unsigned   row_bytes, glyph_bytes, code, offs;
        t_result_word      res;
        w    = eff_dim(cfg_width);
        h    = eff_dim(cfg_height);
        cols = eff_dim(cfg_columns);
        rows = eff_dim(cfg_rows);
        lg   = cfg_depth;
        bpp  = 1 << lg;
        ppb  = 8 >> lg;
        psr  = 3 - lg;
        lum  = (int'(p.red) + int'(p.green) + int'(p.blue)) / 3;
        opa  = (255 - lum) >> (8 - bpp);
        gcol = p.pixel_x / w;
        grow = p.pixel_y / h;
        cx   = p.pixel_x % w;
        cy   = p.pixel_y % h;
        res  = '0;
        if (gcol < cols && grow < rows) begin
            row_bytes   = (w + ppb - 1) >> psr;
            glyph_bytes = h * row_bytes;
            code        = gcol + longint'(cols) * grow;
            offs        = code * glyph_bytes + cy * row_bytes + (cx >> psr);
            sh          = (8 - bpp) - bpp * (cx % ppb);
            res.byte_offset = offs[OFFSET_WIDTH-1:0];
            res.or_bits     = 8'(opa << sh);
            res.in_range    = 1'b1;
        end
        return res;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int unsigned pause_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Coordinate: mostly inside the sheet, some at its edge, some anywhere
    function automatic logic [15:0] pick_coord(int unsigned span);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 16'($urandom_range(0, (span > 65536 ? 65536 : span) - 1));
        if (r < 85) return 16'(int'(span) + int'($urandom_range(0, 3)) - 2);
        return 16'($urandom);
    endfunction

    function automatic logic [DIM_WIDTH-1:0] rand_dim();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return 9'($urandom_range(257, 511));
        if (r < 55) return 9'($urandom_range(1, 16));
        if (r < 85) return 9'($urandom_range(17, 64));
        return 9'($urandom_range(65, 256));
    endfunction

    task automatic push_pixel(logic [15:0] x, logic [15:0] y,
                              logic [7:0] r, logic [7:0] g, logic [7:0] b);
        t_pixel_word p;
        p.pixel_x = x;
        p.pixel_y = y;
        p.red     = r;
        p.green   = g;
        p.blue    = b;
        pixel_backlog.push_back(p);
        pixels_queued++;
    endtask

    task automatic push_random_pixels(int unsigned count);
        int unsigned span_x, span_y, k;
        logic [7:0]  r, g, b;
        span_x = eff_dim(cfg_width) * eff_dim(cfg_columns);
        span_y = eff_dim(cfg_height) * eff_dim(cfg_rows);
        for (k = 0; k < count; k++) begin
            r = $urandom;
            g = $urandom;
            b = $urandom;
            if ($urandom_range(0, 9) == 0) begin
                r = {8{r[0]}};
                g = r;
                b = r;
            end
            push_pixel(pick_coord(span_x), pick_coord(span_y), r, g, b);
        end
    endtask

    // Sender holds off until every word is accepted and every result is back
    task automatic wait_drained();
        while (pixels_sent != pixels_queued || pending_updates.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Register write: setup phase, access phase until pready, then idle
    task automatic reg_write(logic [2:0] idx, logic [APB_DATA_WIDTH-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_GLYPH_WIDTH:   cfg_width   = data[DIM_WIDTH-1:0];
            REG_GLYPH_HEIGHT:  cfg_height  = data[DIM_WIDTH-1:0];
            REG_DEPTH_LOG2:    cfg_depth   = data[DEPTH_WIDTH-1:0];
            REG_SHEET_COLUMNS: cfg_columns = data[DIM_WIDTH-1:0];
            REG_SHEET_ROWS:    cfg_rows    = data[DIM_WIDTH-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_sheet(logic [DIM_WIDTH-1:0] w, logic [DIM_WIDTH-1:0] h,
                             logic [DEPTH_WIDTH-1:0] d, logic [DIM_WIDTH-1:0] cols,
                             logic [DIM_WIDTH-1:0] rows, bit junk);
        logic [APB_DATA_WIDTH-1:0] hi;
        wait_drained();
        // junk above the field width must be dropped by the block
        hi = junk ? ($urandom & ~32'h1FF) : '0;
        reg_write(REG_GLYPH_WIDTH,   hi | w);
        reg_write(REG_GLYPH_HEIGHT,  hi | h);
        reg_write(REG_DEPTH_LOG2,    ($urandom & {32{junk}} & ~32'h3) | d);
        reg_write(REG_SHEET_COLUMNS, hi | cols);
        reg_write(REG_SHEET_ROWS,    hi | rows);
    endtask

    task automatic report_diff(string field, longint unsigned want, longint unsigned got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t mismatch %s: expected 0x%0h, got 0x%0h", $time, field, want, got);
    endtask

    // Driver: new word only when the line is empty or the last word was taken
    always @(negedge i_clk) begin
        if (!i_in_valid || word_taken) begin
            if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pixel_backlog.size() != 0) begin
                i_in_word  <= pixel_backlog.pop_front();
                i_in_valid <= 1'b1;
                gap_left   = calm ? 0 : pause_len();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
        end else if (calm) begin
            i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 99) < 30) begin
            i_out_stall <= 1'b1;
            stall_left  = pause_len();
        end else begin
            i_out_stall <= 1'b0;
            stall_left  = pause_len();
        end
    end

    // Monitor: predict on input acceptance, check on output acceptance
    always @(posedge i_clk) begin
        t_result_word want;
        cycle_count++;
        word_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (word_taken) begin
            pending_updates.push_back(byte_update_for(i_in_word));
            pixels_sent++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_updates.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t unexpected word: expected none, got 0x%0h",
                             $time, o_out_word);
            end else begin
                want = pending_updates.pop_front();
                if (o_out_word.byte_offset !== want.byte_offset)
                    report_diff("byte_offset", want.byte_offset, o_out_word.byte_offset);
                if (o_out_word.or_bits !== want.or_bits)
                    report_diff("or_bits", want.or_bits, o_out_word.or_bits);
                if (o_out_word.in_range !== want.in_range)
                    report_diff("in_range", want.in_range, o_out_word.in_range);
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int unsigned ph;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset geometry: 8x8 glyphs, 16x6 sheet, 1 bit per pixel
        push_pixel(16'd0,     16'd0,     8'd0,   8'd0,   8'd0);
        push_pixel(16'd0,     16'd0,     8'd255, 8'd255, 8'd255);
        push_pixel(16'd1,     16'd0,     8'd255, 8'd255, 8'd254);
        push_pixel(16'd7,     16'd7,     8'd10,  8'd20,  8'd30);
        push_pixel(16'd8,     16'd0,     8'd0,   8'd0,   8'd1);
        push_pixel(16'd127,   16'd47,    8'd1,   8'd2,   8'd3);
        push_pixel(16'd128,   16'd0,     8'd0,   8'd0,   8'd0);
        push_pixel(16'd0,     16'd48,    8'd0,   8'd0,   8'd0);
        push_pixel(16'hFFFF,  16'hFFFF,  8'hFF,  8'hFF,  8'hFF);
        push_pixel(16'hAAAA,  16'h5555,  8'hAA,  8'h55,  8'hAA);
        push_pixel(16'h5555,  16'hAAAA,  8'h55,  8'hAA,  8'h55);
        push_pixel(16'd100,   16'd33,    8'd128, 8'd127, 8'd126);

        // Smallest sheet
        calm = 1'b1;
        set_sheet(9'd1, 9'd1, 2'd0, 9'd1, 9'd1, 1'b0);
        push_pixel(16'd0, 16'd0, 8'd0, 8'd0, 8'd0);
        push_pixel(16'd1, 16'd0, 8'd0, 8'd0, 8'd0);
        push_random_pixels(110);

        // Largest sheet, 8 bits per pixel: offset wraps at 29 bits
        calm = 1'b0;
        set_sheet(9'd256, 9'd256, 2'd3, 9'd256, 9'd256, 1'b0);
        push_pixel(16'hFFFF, 16'hFFFF, 8'd0, 8'd0, 8'd0);
        push_pixel(16'hFF00, 16'hFF00, 8'd3, 8'd3, 8'd3);
        push_random_pixels(110);

        // Zero dimensions behave as one
        set_sheet(9'd0, 9'd0, 2'd1, 9'd0, 9'd0, 1'b0);
        push_random_pixels(110);

        // Oversized dimensions behave as 256
        set_sheet(9'd511, 9'd300, 2'd2, 9'd400, 9'd257, 1'b0);
        push_random_pixels(110);

        // Odd widths with row padding; a write to a missing register changes nothing
        set_sheet(9'd3, 9'd5, 2'd1, 9'd7, 9'd3, 1'b0);
        reg_write(REG_SPARE, $urandom);
        push_random_pixels(110);

        for (ph = 0; ph < 9; ph++) begin
            calm = (ph % 4 == 1);
            set_sheet(rand_dim(), rand_dim(), 2'($urandom_range(0, 3)),
                      rand_dim(), rand_dim(), ph[0]);
            push_random_pixels(100);
        end

        wait_drained();
        if (fail_count == 0 && pending_updates.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
